/* hw/rtl/ckbw_pkg.sv */
// ----------------------------------------------------------------------------
// ckbw_pkg: shared types and constants of the chroma-key blit writer
// Register map, register field widths and the configuration bundle that
// the register file hands to the address datapath.
// ----------------------------------------------------------------------------
package ckbw_pkg;

  // Default sizing of the top level.
  localparam int unsigned MAX_DIM_DEFAULT   = 4096;
  localparam int unsigned ADDR_BITS_DEFAULT = 24;

  // Fixed register field widths.
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned PIXEL_W    = 8;
  localparam int unsigned STRIDE_W   = 13;
  localparam int unsigned START_W    = 24;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 4;

  // Mode register bits.
  localparam int unsigned MODE_RECT_BIT = 0;
  localparam int unsigned MODE_KEY_BIT  = 1;

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE          = 4'd0,
    REG_SOURCE_WIDTH  = 4'd1,
    REG_SOURCE_HEIGHT = 4'd2,
    REG_VIEW_WIDTH    = 4'd3,
    REG_VIEW_HEIGHT   = 4'd4,
    REG_KEY_COLOR     = 4'd5,
    REG_DEST_STRIDE   = 4'd6,
    REG_DEST_START    = 4'd7
  } cfg_reg_e;

  // Register contents plus a one-cycle restart pulse on every known write.
  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [DIM_W-1:0]    source_width;
    logic [DIM_W-1:0]    source_height;
    logic [DIM_W-1:0]    view_width;
    logic [DIM_W-1:0]    view_height;
    logic [PIXEL_W-1:0]  key_color;
    logic [STRIDE_W-1:0] dest_stride;
    logic [START_W-1:0]  dest_start;
    logic                restart;
  } cfg_t;

endpackage

/* hw/rtl/ckbw_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ckbw_cfg_regs: configuration register file
// Decodes writes by index, keeps the register values and flags a region
// restart for every write to a known register.
// ----------------------------------------------------------------------------
module ckbw_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ckbw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ckbw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output ckbw_pkg::cfg_t                 cfg_o
);
  import ckbw_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i;

  always_comb begin
    cfg_d         = cfg_q;
    cfg_d.restart = 1'b0;
    if (wr) begin
      cfg_d.restart = 1'b1;
      unique case (cfg_reg_e'(cfg_index_i))
        REG_MODE:          cfg_d.mode          = cfg_data_i[MODE_W-1:0];
        REG_SOURCE_WIDTH:  cfg_d.source_width  = cfg_data_i[DIM_W-1:0];
        REG_SOURCE_HEIGHT: cfg_d.source_height = cfg_data_i[DIM_W-1:0];
        REG_VIEW_WIDTH:    cfg_d.view_width    = cfg_data_i[DIM_W-1:0];
        REG_VIEW_HEIGHT:   cfg_d.view_height   = cfg_data_i[DIM_W-1:0];
        REG_KEY_COLOR:     cfg_d.key_color     = cfg_data_i[PIXEL_W-1:0];
        REG_DEST_STRIDE:   cfg_d.dest_stride   = cfg_data_i[STRIDE_W-1:0];
        REG_DEST_START:    cfg_d.dest_start    = cfg_data_i[START_W-1:0];
        default:           cfg_d.restart       = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/chroma_key_blit_writer.sv */
// ----------------------------------------------------------------------------
// chroma_key_blit_writer: write side of an 8-bit color-key blitter
// Turns a raster-order stream of source pixels into destination writes.
// ----------------------------------------------------------------------------
// Each accepted pixel beat yields one write beat carrying the destination
// address (row base plus column, wrapping at ADDR_BITS), the pixel, a write
// enable that drops when keying is on and the pixel equals the key color,
// and a last flag on the final pixel of the region. The block sustains one
// pixel per clock while out_stall_i stays low: a pixel lands in an input
// register, then one add of the row base and column plus two extent
// compares feed the result register. Register writes take effect in the
// cycle after the write and restart the region; they are only legal while
// no pixel is in flight. If the active width or height is zero, pixels are
// consumed and no write beat is produced.
// ----------------------------------------------------------------------------
module chroma_key_blit_writer #(
  parameter int unsigned MAX_DIM   = ckbw_pkg::MAX_DIM_DEFAULT,
  parameter int unsigned ADDR_BITS = ckbw_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ckbw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ckbw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Source pixel channel.
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ckbw_pkg::PIXEL_W-1:0]    pixel_in_i,
  // Destination write channel.
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ADDR_BITS-1:0]            dest_address_o,
  output logic [ckbw_pkg::PIXEL_W-1:0]    pixel_out_o,
  output logic                            write_enable_o,
  output logic                            last_pixel_o
);
  import ckbw_pkg::*;

  // Counters hold 0 .. MAX_DIM-1; extents hold 0 .. MAX_DIM after clamping.
  localparam int unsigned CntW  = $clog2(MAX_DIM);
  localparam int unsigned LimW  = $clog2(MAX_DIM + 1);
  localparam int unsigned ExtW  = (LimW > DIM_W) ? LimW : DIM_W;
  localparam logic [ExtW-1:0] MaxExt = ExtW'(MAX_DIM);

  cfg_t cfg;

  ckbw_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Handshake: the input register drains into the result register whenever
  // the result register is empty or its beat is taken this cycle.
  logic                s1_valid_q, s1_valid_d;
  logic [PIXEL_W-1:0]  s1_pixel_q;
  logic                out_free, s1_move, in_accept;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  // Active extent, saturated at MAX_DIM.
  logic [ExtW-1:0] raw_w, raw_h, ext_w, ext_h;
  logic            rect_mode, key_on, nonempty;

  assign rect_mode = cfg.mode[MODE_RECT_BIT];
  assign key_on    = cfg.mode[MODE_KEY_BIT];
  assign raw_w = ExtW'(rect_mode ? cfg.view_width  : cfg.source_width);
  assign raw_h = ExtW'(rect_mode ? cfg.view_height : cfg.source_height);
  assign ext_w = (raw_w > MaxExt) ? MaxExt : raw_w;
  assign ext_h = (raw_h > MaxExt) ? MaxExt : raw_h;
  assign nonempty = (ext_w != '0) && (ext_h != '0);

  // Raster position and the destination address of the current row.
  logic [CntW-1:0]      col_q, col_d, row_q, row_d;
  logic [ADDR_BITS-1:0] row_base_q, row_base_d;
  logic                 last_col, last_row, step;
  logic [ADDR_BITS-1:0] addr;

  assign last_col = (ExtW'(col_q) + ExtW'(1)) >= ext_w;
  assign last_row = (ExtW'(row_q) + ExtW'(1)) >= ext_h;
  assign addr     = row_base_q + ADDR_BITS'(col_q);
  assign step     = s1_move && nonempty;

  // A register write always wins; the user must only issue it while the pipe is empty, the block does not enforce this.
  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    row_base_d = row_base_q;
    priority if (cfg.restart) begin
      col_d      = '0;
      row_d      = '0;
      row_base_d = ADDR_BITS'(cfg.dest_start);
    end else if (step) begin
      priority if (!last_col) begin
        col_d = col_q + CntW'(1);
      end else if (!last_row) begin
        col_d      = '0;
        row_d      = row_q + CntW'(1);
        row_base_d = row_base_q + ADDR_BITS'(cfg.dest_stride);
      end else begin
        // Region complete: the next pixel starts a fresh copy.
        col_d      = '0;
        row_d      = '0;
        row_base_d = ADDR_BITS'(cfg.dest_start);
      end
    end
  end

  // Result register.
  logic out_valid_q, out_valid_d;
  logic [ADDR_BITS-1:0] out_addr_q;
  logic [PIXEL_W-1:0]   out_pixel_q;
  logic                 out_we_q, out_last_q;

  always_comb begin
    if (s1_move) begin
      out_valid_d = nonempty;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      row_base_q  <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      col_q       <= col_d;
      row_q       <= row_d;
      row_base_q  <= row_base_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pixel_q <= pixel_in_i;
    end
    if (step) begin
      out_addr_q  <= addr;
      out_pixel_q <= s1_pixel_q;
      out_we_q    <= !(key_on && (s1_pixel_q == cfg.key_color));
      out_last_q  <= last_col && last_row;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign dest_address_o = out_addr_q;
  assign pixel_out_o    = out_pixel_q;
  assign write_enable_o = out_we_q;
  assign last_pixel_o   = out_last_q;

  // The column and row counters stay inside the active extent. In the
  // cycle of a restart the extent may already be new while the counters
  // are still being cleared.
  a_col_in_extent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cfg.restart && (ext_w != '0)) |-> (ExtW'(col_q) < ext_w))
    else $error("column counter outside active width");

  a_row_in_extent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cfg.restart && (ext_h != '0)) |-> (ExtW'(row_q) < ext_h))
    else $error("row counter outside active height");

  // A register write leaves the raster position at the region origin.
  a_restart_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg.restart |=> (col_q == '0) && (row_q == '0))
    else $error("region restart did not clear the raster position");

  // An empty extent never produces a write beat.
  a_empty_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_move && !nonempty && !cfg.restart) |=> !out_valid_q)
    else $error("write beat produced for an empty extent");

endmodule
